>>> hw/rtl/cpec_pkg.sv
// Shared types, constants and saturation helper for the circle pair collision block.
`default_nettype none

package cpec_pkg;

  localparam int FRAC_W   = 16;                      // Q16.16 fraction bits
  localparam int RATIO_W  = 30;                      // mass ratio fraction bits
  localparam int ELASTIC  = 2;                       // elastic exchange factor
  localparam int KSH      = RATIO_W - ELASTIC / 2;   // factor folded into the shift
  localparam int SAT_W    = 40;                      // headroom for saturating sums

  localparam int ROOT_W   = 32;                      // square root steps / result bits
  localparam int NQ_W     = 17;                      // normal quotient bits
  localparam int KQ_W     = 31;                      // mass ratio quotient bits

  localparam logic [KQ_W-1:0] K_ONE  = KQ_W'(64'd1 << RATIO_W);
  localparam logic [KQ_W-1:0] K_HALF = KQ_W'(64'd1 << (RATIO_W - 1));

  localparam logic signed [SAT_W-1:0] S32_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] S32_MIN = SAT_W'(-64'sd2147483648);

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic        [30:0] a_radius;
    logic        [30:0] a_mass;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic        [30:0] b_radius;
    logic        [30:0] b_mass;
  } cpec_in_t;

  typedef struct packed {
    logic signed [31:0] new_a_pos_x;
    logic signed [31:0] new_a_pos_y;
    logic signed [31:0] new_a_vel_x;
    logic signed [31:0] new_a_vel_y;
    logic signed [31:0] new_b_pos_x;
    logic signed [31:0] new_b_pos_y;
    logic signed [31:0] new_b_vel_x;
    logic signed [31:0] new_b_vel_y;
    logic               hit;
  } cpec_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cpec_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module cpec_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32,
  parameter int Q_W   = cpec_pkg::NQ_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic             rem_nz_o
);

  // Needs num_i >> Q_W below den_i; otherwise the result is meaningless.
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [Q_W-1:0]   low_p;
    logic [Q_W-1:0]   quo_p;
    logic [DEN_W:0]   t_s;
    logic             ge_s;

    if (k == 0) begin : g_first
      assign rem_p = DEN_W'(num_i >> Q_W);
      assign low_p = num_i[Q_W-1:0];
      assign quo_p = '0;
      assign den_p = den_i;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign low_p = low_r[k-1];
      assign quo_p = quo_r[k-1];
      assign den_p = den_r[k-1];
    end

    assign t_s  = {rem_p, low_p[Q_W-1]};
    assign ge_s = t_s >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge_s ? DEN_W'(t_s - {1'b0, den_p}) : DEN_W'(t_s);
      quo_r[k] <= {quo_p[Q_W-2:0], ge_s};
    end

    if (k < Q_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        low_r[k] <= {low_p[Q_W-2:0], 1'b0};
        den_r[k] <= den_p;
      end
    end
  end

  assign quo_o    = quo_r[Q_W-1];
  assign rem_nz_o = |rem_r[Q_W-1];

endmodule

`default_nettype wire

>>> hw/rtl/circle_pair_elastic_collision.sv
// Top level: pipelined elastic collision response for one pair of circles per clock.
// Throughput: one request every cycle; busy is always low and results cannot be held off.
// Depth is set by the 32-stage square root, followed by the 17-stage normal divide; the
// 31-stage mass ratio divide runs alongside the square root.
// Reset (rst_n, synchronous) clears only the valid bits; data registers are not reset.
`default_nettype none

module circle_pair_elastic_collision (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  cpec_pkg::cpec_in_t  in_data,
  output logic                busy,
  output logic                out_valid,
  output cpec_pkg::cpec_out_t out_data
);

  localparam int SatW   = cpec_pkg::SAT_W;
  localparam int FracW  = cpec_pkg::FRAC_W;
  localparam int Ksh    = cpec_pkg::KSH;
  localparam int RootW  = cpec_pkg::ROOT_W;
  localparam int NqW    = cpec_pkg::NQ_W;
  localparam int KqW    = cpec_pkg::KQ_W;
  localparam int RatioW = cpec_pkg::RATIO_W;

  // Register depth of each stage, counted from the edge that takes the request.
  localparam int D_D2   = 3;                  // squared distance
  localparam int D_MAG  = D_D2 + RootW;       // square root done
  localparam int D_KIN  = D_MAG - KqW;        // mass divide fed here, ends with the root
  localparam int D_MID  = D_MAG + 1;          // hit, overlap, |dx|, |dy|, ratios
  localparam int D_NQ   = D_MID + NqW;        // normal quotient done
  localparam int D_N    = D_NQ + 1;           // signed normal
  localparam int D_MUL1 = D_N + 1;            // projection products
  localparam int D_VN   = D_MUL1 + 1;         // normal/tangential speeds, push
  localparam int D_DV   = D_VN + 1;           // speed differences
  localparam int D_MUL2 = D_DV + 1;           // difference times ratio
  localparam int D_NV   = D_MUL2 + 1;         // new normal speeds
  localparam int D_MUL3 = D_NV + 1;           // back-projection products
  localparam int D_OUT  = D_MUL3 + 1;         // output register
  localparam int LastD  = D_OUT - 1;

  // Side data that travels with each request down the pipe; fields fill in as known.
  typedef struct packed {
    cpec_pkg::cpec_in_t req;
    logic               hit;
    logic [31:0]        ov;
    logic [KqW-1:0]     ka;
    logic [KqW-1:0]     kb;
    logic               negx;
    logic               negy;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [34:0] px;
    logic signed [34:0] py;
    logic signed [31:0] vn_a;
    logic signed [31:0] vt_a;
    logic signed [31:0] vn_b;
    logic signed [31:0] vt_b;
  } carry_t;

  carry_t carry_r   [1:LastD];
  carry_t carry_nxt [1:LastD];
  logic   valid_r   [1:LastD];
  logic   out_valid_r;
  cpec_pkg::cpec_out_t out_data_r;

  // No back-pressure anywhere: every request is taken.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 1; d <= LastD; d++) begin
        valid_r[d] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      valid_r[1] <= start;
      for (int d = 2; d <= LastD; d++) begin
        valid_r[d] <= valid_r[d-1];
      end
      out_valid_r <= valid_r[LastD];
    end
  end

  // ---------------------------------------------------------------------------
  // Depth 1..3: centre difference, squares, squared distance
  // ---------------------------------------------------------------------------
  logic signed [32:0] dxd_s, dyd_s;
  logic signed [31:0] dx_r, dy_r;
  logic signed [63:0] sqx_s, sqy_s;
  logic [62:0]        sqx_r, sqy_r;
  logic [63:0]        d2_r;

  assign dxd_s = 33'($signed(in_data.b_pos_x)) - 33'($signed(in_data.a_pos_x));
  assign dyd_s = 33'($signed(in_data.b_pos_y)) - 33'($signed(in_data.a_pos_y));
  assign sqx_s = dx_r * dx_r;
  assign sqy_s = dy_r * dy_r;

  always_ff @(posedge clk) begin
    dx_r  <= cpec_pkg::sat32(SatW'(dxd_s));
    dy_r  <= cpec_pkg::sat32(SatW'(dyd_s));
    sqx_r <= sqx_s[62:0];
    sqy_r <= sqy_s[62:0];
    d2_r  <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // ---------------------------------------------------------------------------
  // Depth 4..35: digit-by-digit square root, one result bit per stage
  // ---------------------------------------------------------------------------
  logic [33:0] rt_rem_r  [RootW];
  logic [31:0] rt_root_r [RootW];
  logic [63:0] rt_rad_r  [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_root
    logic [33:0] rem_p;
    logic [31:0] root_p;
    logic [63:0] rad_p;
    logic [35:0] t_s;
    logic [35:0] trial_s;
    logic        ge_s;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = d2_r;
    end else begin : g_next
      assign rem_p  = rt_rem_r[j-1];
      assign root_p = rt_root_r[j-1];
      assign rad_p  = rt_rad_r[j-1];
    end

    assign t_s     = {rem_p, rad_p[63:62]};
    assign trial_s = {2'b00, root_p, 2'b01};
    assign ge_s    = t_s >= trial_s;

    always_ff @(posedge clk) begin
      rt_rem_r[j]  <= ge_s ? 34'(t_s - trial_s) : 34'(t_s);
      rt_root_r[j] <= {root_p[30:0], ge_s};
      rt_rad_r[j]  <= {rad_p[61:0], 2'b00};
    end
  end

  logic [31:0] mag_s;
  assign mag_s = rt_root_r[RootW-1];

  // Mass ratio kA = am * 2^30 / (am + bm), in step with the root.
  logic [KqW-1:0] kq_s;
  logic           krem_nz_s;

  cpec_div #(
    .NUM_W (KqW + RatioW),
    .DEN_W (32),
    .Q_W   (KqW)
  ) u_kdiv (
    .clk      (clk),
    .num_i    ({carry_r[D_KIN].req.a_mass, RatioW'(0)}),
    .den_i    ({1'b0, carry_r[D_KIN].req.a_mass} + {1'b0, carry_r[D_KIN].req.b_mass}),
    .quo_o    (kq_s),
    .rem_nz_o (krem_nz_s)
  );

  // ---------------------------------------------------------------------------
  // Depth 36: hit test, overlap, magnitudes for the normal divide
  // ---------------------------------------------------------------------------
  carry_t             cm_s;
  logic signed [32:0] dxm_d_s, dym_d_s;
  logic signed [31:0] dxm_s, dym_s;
  logic [31:0]        rsum_s;
  logic               mzero_s;
  logic [31:0]        absdx_r, absdy_r, mag_m_r;

  assign cm_s    = carry_r[D_MAG];
  assign dxm_d_s = 33'($signed(cm_s.req.b_pos_x)) - 33'($signed(cm_s.req.a_pos_x));
  assign dym_d_s = 33'($signed(cm_s.req.b_pos_y)) - 33'($signed(cm_s.req.a_pos_y));
  assign dxm_s   = cpec_pkg::sat32(SatW'(dxm_d_s));
  assign dym_s   = cpec_pkg::sat32(SatW'(dym_d_s));
  assign rsum_s  = {1'b0, cm_s.req.a_radius} + {1'b0, cm_s.req.b_radius};
  // both masses zero: treated as equal masses
  assign mzero_s = (cm_s.req.a_mass == '0) && (cm_s.req.b_mass == '0);

  always_ff @(posedge clk) begin
    absdx_r <= dxm_s[31] ? 32'(-dxm_s) : 32'(dxm_s);
    absdy_r <= dym_s[31] ? 32'(-dym_s) : 32'(dym_s);
    mag_m_r <= mag_s;
  end

  // ---------------------------------------------------------------------------
  // Depth 37..53: unit normal, |d| * 2^16 / mag
  // ---------------------------------------------------------------------------
  logic [NqW-1:0] qx_s, qy_s;

  cpec_div #(
    .NUM_W (32 + FracW),
    .DEN_W (32),
    .Q_W   (NqW)
  ) u_nxdiv (
    .clk      (clk),
    .num_i    ({absdx_r, FracW'(0)}),
    .den_i    (mag_m_r),
    .quo_o    (qx_s),
    .rem_nz_o ()
  );

  cpec_div #(
    .NUM_W (32 + FracW),
    .DEN_W (32),
    .Q_W   (NqW)
  ) u_nydiv (
    .clk      (clk),
    .num_i    ({absdy_r, FracW'(0)}),
    .den_i    (mag_m_r),
    .quo_o    (qy_s),
    .rem_nz_o ()
  );

  // ---------------------------------------------------------------------------
  // Depth 55: projections onto the normal and tangent
  // ---------------------------------------------------------------------------
  carry_t             c1_s;
  logic signed [50:0] povx_r, povy_r;
  logic signed [49:0] pa_xx_r, pa_yy_r, pa_yx_r, pa_xy_r;
  logic signed [49:0] pb_xx_r, pb_yy_r, pb_yx_r, pb_xy_r;

  assign c1_s = carry_r[D_N];

  always_ff @(posedge clk) begin
    povx_r  <= $signed({1'b0, c1_s.ov}) * c1_s.nx;
    povy_r  <= $signed({1'b0, c1_s.ov}) * c1_s.ny;
    pa_xx_r <= $signed(c1_s.req.a_vel_x) * c1_s.nx;
    pa_yy_r <= $signed(c1_s.req.a_vel_y) * c1_s.ny;
    pa_yx_r <= $signed(c1_s.req.a_vel_y) * c1_s.nx;
    pa_xy_r <= $signed(c1_s.req.a_vel_x) * c1_s.ny;
    pb_xx_r <= $signed(c1_s.req.b_vel_x) * c1_s.nx;
    pb_yy_r <= $signed(c1_s.req.b_vel_y) * c1_s.ny;
    pb_yx_r <= $signed(c1_s.req.b_vel_y) * c1_s.nx;
    pb_xy_r <= $signed(c1_s.req.b_vel_x) * c1_s.ny;
  end

  // Depth 56 sums, floored by arithmetic shift
  logic signed [49:0] vna_sum_s, vta_sum_s, vnb_sum_s, vtb_sum_s;
  logic signed [49:0] vna_sh_s, vta_sh_s, vnb_sh_s, vtb_sh_s;
  logic signed [50:0] pushx_sh_s, pushy_sh_s;

  assign vna_sum_s  = pa_xx_r + pa_yy_r;
  assign vta_sum_s  = pa_yx_r - pa_xy_r;
  assign vnb_sum_s  = pb_xx_r + pb_yy_r;
  assign vtb_sum_s  = pb_yx_r - pb_xy_r;
  assign vna_sh_s   = vna_sum_s >>> FracW;
  assign vta_sh_s   = vta_sum_s >>> FracW;
  assign vnb_sh_s   = vnb_sum_s >>> FracW;
  assign vtb_sh_s   = vtb_sum_s >>> FracW;
  assign pushx_sh_s = povx_r >>> FracW;
  assign pushy_sh_s = povy_r >>> FracW;

  // ---------------------------------------------------------------------------
  // Depth 57..59: one-dimensional elastic exchange of the normal speeds
  // ---------------------------------------------------------------------------
  carry_t             cv_s, cd_s, ck_s;
  logic signed [32:0] dva_r, dvb_r;
  logic signed [64:0] pma_r, pmb_r;
  logic signed [64:0] pma_sh_s, pmb_sh_s;
  logic signed [SatW-1:0] na_sum_s, nb_sum_s;

  assign cv_s = carry_r[D_VN];
  assign cd_s = carry_r[D_DV];
  assign ck_s = carry_r[D_MUL2];

  always_ff @(posedge clk) begin
    dva_r <= 33'(cv_s.vn_b) - 33'(cv_s.vn_a);
    dvb_r <= 33'(cv_s.vn_a) - 33'(cv_s.vn_b);
    pma_r <= dva_r * $signed({1'b0, cd_s.kb});
    pmb_r <= dvb_r * $signed({1'b0, cd_s.ka});
  end

  assign pma_sh_s = pma_r >>> Ksh;
  assign pmb_sh_s = pmb_r >>> Ksh;
  assign na_sum_s = SatW'(pma_sh_s) + SatW'(ck_s.vn_a);
  assign nb_sum_s = SatW'(pmb_sh_s) + SatW'(ck_s.vn_b);

  // ---------------------------------------------------------------------------
  // Depth 60: back to x/y
  // ---------------------------------------------------------------------------
  carry_t             cb_s;
  logic signed [49:0] qa1_r, qa2_r, qa3_r, qa4_r;
  logic signed [49:0] qb1_r, qb2_r, qb3_r, qb4_r;

  assign cb_s = carry_r[D_NV];

  always_ff @(posedge clk) begin
    qa1_r <= cb_s.vn_a * cb_s.nx;
    qa2_r <= cb_s.vt_a * cb_s.ny;
    qa3_r <= cb_s.vn_a * cb_s.ny;
    qa4_r <= cb_s.vt_a * cb_s.nx;
    qb1_r <= cb_s.vn_b * cb_s.nx;
    qb2_r <= cb_s.vt_b * cb_s.ny;
    qb3_r <= cb_s.vn_b * cb_s.ny;
    qb4_r <= cb_s.vt_b * cb_s.nx;
  end

  // ---------------------------------------------------------------------------
  // Carry line, with fields filled at the depth where they become known
  // ---------------------------------------------------------------------------
  always_comb begin
    carry_nxt[1]     = '0;
    carry_nxt[1].req = in_data;
    for (int d = 2; d <= LastD; d++) begin
      carry_nxt[d] = carry_r[d-1];
    end

    carry_nxt[D_MID].hit  = (mag_s != '0) && (mag_s < rsum_s);
    carry_nxt[D_MID].ov   = rsum_s - mag_s;
    carry_nxt[D_MID].ka   = mzero_s ? cpec_pkg::K_HALF : kq_s;
    carry_nxt[D_MID].kb   = mzero_s ? cpec_pkg::K_HALF
                                    : cpec_pkg::K_ONE - kq_s - KqW'(krem_nz_s);
    carry_nxt[D_MID].negx = dxm_s[31];
    carry_nxt[D_MID].negy = dym_s[31];

    carry_nxt[D_N].nx = carry_r[D_NQ].negx ? -$signed({1'b0, qx_s}) : $signed({1'b0, qx_s});
    carry_nxt[D_N].ny = carry_r[D_NQ].negy ? -$signed({1'b0, qy_s}) : $signed({1'b0, qy_s});

    carry_nxt[D_VN].px   = 35'(pushx_sh_s);
    carry_nxt[D_VN].py   = 35'(pushy_sh_s);
    carry_nxt[D_VN].vn_a = cpec_pkg::sat32(SatW'(vna_sh_s));
    carry_nxt[D_VN].vt_a = cpec_pkg::sat32(SatW'(vta_sh_s));
    carry_nxt[D_VN].vn_b = cpec_pkg::sat32(SatW'(vnb_sh_s));
    carry_nxt[D_VN].vt_b = cpec_pkg::sat32(SatW'(vtb_sh_s));

    // normal speeds replaced by their post-collision values
    carry_nxt[D_NV].vn_a = cpec_pkg::sat32(na_sum_s);
    carry_nxt[D_NV].vn_b = cpec_pkg::sat32(nb_sum_s);
  end

  always_ff @(posedge clk) begin
    for (int d = 1; d <= LastD; d++) begin
      carry_r[d] <= carry_nxt[d];
    end
  end

  // ---------------------------------------------------------------------------
  // Depth 61: final sums, push-out, pass-through on no hit
  // ---------------------------------------------------------------------------
  carry_t             co_s;
  logic signed [49:0] vxa_s, vya_s, vxb_s, vyb_s;
  logic signed [SatW-1:0] pax_s, pay_s, pbx_s, pby_s;
  cpec_pkg::cpec_out_t res_s;

  assign co_s  = carry_r[LastD];
  assign vxa_s = (qa1_r - qa2_r) >>> FracW;
  assign vya_s = (qa3_r + qa4_r) >>> FracW;
  assign vxb_s = (qb1_r - qb2_r) >>> FracW;
  assign vyb_s = (qb3_r + qb4_r) >>> FracW;
  assign pax_s = SatW'($signed(co_s.req.a_pos_x)) - SatW'(co_s.px);
  assign pay_s = SatW'($signed(co_s.req.a_pos_y)) - SatW'(co_s.py);
  assign pbx_s = SatW'($signed(co_s.req.b_pos_x)) + SatW'(co_s.px);
  assign pby_s = SatW'($signed(co_s.req.b_pos_y)) + SatW'(co_s.py);

  always_comb begin
    if (co_s.hit) begin
      res_s.new_a_pos_x = cpec_pkg::sat32(pax_s);
      res_s.new_a_pos_y = cpec_pkg::sat32(pay_s);
      res_s.new_a_vel_x = cpec_pkg::sat32(SatW'(vxa_s));
      res_s.new_a_vel_y = cpec_pkg::sat32(SatW'(vya_s));
      res_s.new_b_pos_x = cpec_pkg::sat32(pbx_s);
      res_s.new_b_pos_y = cpec_pkg::sat32(pby_s);
      res_s.new_b_vel_x = cpec_pkg::sat32(SatW'(vxb_s));
      res_s.new_b_vel_y = cpec_pkg::sat32(SatW'(vyb_s));
      res_s.hit         = 1'b1;
    end else begin
      res_s.new_a_pos_x = co_s.req.a_pos_x;
      res_s.new_a_pos_y = co_s.req.a_pos_y;
      res_s.new_a_vel_x = co_s.req.a_vel_x;
      res_s.new_a_vel_y = co_s.req.a_vel_y;
      res_s.new_b_pos_x = co_s.req.b_pos_x;
      res_s.new_b_pos_y = co_s.req.b_pos_y;
      res_s.new_b_vel_x = co_s.req.b_vel_x;
      res_s.new_b_vel_y = co_s.req.b_vel_y;
      res_s.hit         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res_s;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> bench/circle_pair_elastic_collision_chk.sv
// Checker for the circle pair collision block: predicts each result and compares it.
module circle_pair_elastic_collision_chk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  cpec_pkg::cpec_in_t  in_data,
  input  logic                out_valid,
  input  cpec_pkg::cpec_out_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  pairs_seen,
  output int                  hits_seen
);

  cpec_pkg::cpec_out_t expected_pairs[$];

  initial begin
    fail_count = 0;
    pairs_seen = 0;
    hits_seen  = 0;
  end

  assign pending = expected_pairs.size();

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root64(input longint unsigned d);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > d) b = b >> 2;
    while (b != 0) begin
      if (d >= r + b) begin
        d = d - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Collision response for one request, in 64 bit signed arithmetic.
  function automatic cpec_pkg::cpec_out_t predict_collision(input cpec_pkg::cpec_in_t p);
    cpec_pkg::cpec_out_t o;
    longint ax, ay, avx, avy, bx, by, bvx, bvy, ar, am, br, bm;
    longint dx, dy, mag, rsum, nx, ny, ov, px, py;
    longint vna, vta, vnb, vtb, msum, ka, kb, na, nb;
    longint unsigned d2;
    ax = p.a_pos_x;  ay = p.a_pos_y;  avx = p.a_vel_x;  avy = p.a_vel_y;
    bx = p.b_pos_x;  by = p.b_pos_y;  bvx = p.b_vel_x;  bvy = p.b_vel_y;
    ar = longint'({33'd0, p.a_radius});  am = longint'({33'd0, p.a_mass});
    br = longint'({33'd0, p.b_radius});  bm = longint'({33'd0, p.b_mass});
    dx = clip32(bx - ax);
    dy = clip32(by - ay);
    d2 = longint'(dx * dx) + longint'(dy * dy);
    mag = longint'(root64(d2));
    rsum = ar + br;
    o = '{new_a_pos_x: p.a_pos_x, new_a_pos_y: p.a_pos_y,
          new_a_vel_x: p.a_vel_x, new_a_vel_y: p.a_vel_y,
          new_b_pos_x: p.b_pos_x, new_b_pos_y: p.b_pos_y,
          new_b_vel_x: p.b_vel_x, new_b_vel_y: p.b_vel_y, hit: 1'b0};
    if (mag == 0 || mag >= rsum) return o;
    nx = (dx <<< cpec_pkg::FRAC_W) / mag;
    ny = (dy <<< cpec_pkg::FRAC_W) / mag;
    ov = rsum - mag;
    px = (ov * nx) >>> cpec_pkg::FRAC_W;
    py = (ov * ny) >>> cpec_pkg::FRAC_W;
    vna = clip32((avx * nx + avy * ny) >>> cpec_pkg::FRAC_W);
    vta = clip32((avy * nx - avx * ny) >>> cpec_pkg::FRAC_W);
    vnb = clip32((bvx * nx + bvy * ny) >>> cpec_pkg::FRAC_W);
    vtb = clip32((bvy * nx - bvx * ny) >>> cpec_pkg::FRAC_W);
    msum = am + bm;
    if (msum == 0) begin
      ka = 64'sd1 <<< (cpec_pkg::RATIO_W - 1);
      kb = ka;
    end else begin
      ka = (am <<< cpec_pkg::RATIO_W) / msum;
      kb = (bm <<< cpec_pkg::RATIO_W) / msum;
    end
    na = clip32(vna + (((vnb - vna) * kb) >>> cpec_pkg::KSH));
    nb = clip32(vnb + (((vna - vnb) * ka) >>> cpec_pkg::KSH));
    o.new_a_pos_x = 32'(clip32(ax - px));
    o.new_a_pos_y = 32'(clip32(ay - py));
    o.new_a_vel_x = 32'(clip32((na * nx - vta * ny) >>> cpec_pkg::FRAC_W));
    o.new_a_vel_y = 32'(clip32((na * ny + vta * nx) >>> cpec_pkg::FRAC_W));
    o.new_b_pos_x = 32'(clip32(bx + px));
    o.new_b_pos_y = 32'(clip32(by + py));
    o.new_b_vel_x = 32'(clip32((nb * nx - vtb * ny) >>> cpec_pkg::FRAC_W));
    o.new_b_vel_y = 32'(clip32((nb * ny + vtb * nx) >>> cpec_pkg::FRAC_W));
    o.hit = 1'b1;
    return o;
  endfunction

  function automatic int field_ok(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e === a) return 1;
    $display("%0t mismatch %s: expected %h actual %h", $time, nm, e, a);
    return 0;
  endfunction

  always @(posedge clk) begin
    cpec_pkg::cpec_out_t e;
    int ok;
    if (rst_n) begin
      if (start && !busy) begin
        expected_pairs.push_back(predict_collision(in_data));
        pairs_seen++;
      end
      if (out_valid) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          e = expected_pairs.pop_front();
          ok = field_ok("new_a_pos_x", e.new_a_pos_x, out_data.new_a_pos_x)
             & field_ok("new_a_pos_y", e.new_a_pos_y, out_data.new_a_pos_y)
             & field_ok("new_a_vel_x", e.new_a_vel_x, out_data.new_a_vel_x)
             & field_ok("new_a_vel_y", e.new_a_vel_y, out_data.new_a_vel_y)
             & field_ok("new_b_pos_x", e.new_b_pos_x, out_data.new_b_pos_x)
             & field_ok("new_b_pos_y", e.new_b_pos_y, out_data.new_b_pos_y)
             & field_ok("new_b_vel_x", e.new_b_vel_x, out_data.new_b_vel_x)
             & field_ok("new_b_vel_y", e.new_b_vel_y, out_data.new_b_vel_y)
             & field_ok("hit", 32'(e.hit), 32'(out_data.hit));
          if (!ok) fail_count++;
          if (e.hit) hits_seen++;
        end
      end
    end
  end
endmodule

>>> bench/circle_pair_elastic_collision_tb.sv
// Testbench top: drives circle pair requests into the block and gives the verdict.
module circle_pair_elastic_collision_tb;

  localparam int LATENCY = 61;
  localparam int LIMIT   = 200000;   // cycles

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  cpec_pkg::cpec_in_t  in_data = '0;
  logic                busy;
  logic                out_valid;
  cpec_pkg::cpec_out_t out_data;
  int        fail_count, pending, pairs_seen, hits_seen;
  int        cycles = 0;
  int        idle_pct = 0;

  circle_pair_elastic_collision u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  circle_pair_elastic_collision_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .fail_count(fail_count),
    .pending(pending), .pairs_seen(pairs_seen), .hits_seen(hits_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung pipeline ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one request and hold it until taken. start stays high between
  // back-to-back requests; it only drops for idle cycles.
  task automatic send_pair(input cpec_pkg::cpec_in_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [30:0] pick_mass();
    logic [30:0] m;
    case ($urandom_range(2))
      0:       m = 31'($urandom_range(1, 32'h0010_0000));
      1:       m = 31'($urandom);
      default: m = 31'($urandom_range(32'h0000_8000, 32'h0002_0000));
    endcase
    return (m == 0) ? 31'd1 : m;
  endfunction

  // Random pair. Most are placed close together so they overlap and take the
  // full collision path; the rest are wide-spaced pairs with huge radii or full-range noise.
  function automatic cpec_pkg::cpec_in_t make_pair();
    cpec_pkg::cpec_in_t p;
    int kind;
    kind = $urandom_range(9);
    p.a_pos_x = $urandom;  p.a_pos_y = $urandom;
    p.a_vel_x = $urandom;  p.a_vel_y = $urandom;
    p.b_vel_x = $urandom;  p.b_vel_y = $urandom;
    p.a_radius = 31'($urandom);  p.b_radius = 31'($urandom);
    p.a_mass = pick_mass();      p.b_mass = pick_mass();
    if (kind < 6) begin
      // near, realistic scale: centres within a few units, velocities moderate in most
      p.a_pos_x = $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
      p.a_pos_y = $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
      p.b_pos_x = p.a_pos_x + $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      p.b_pos_y = p.a_pos_y + $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      p.a_radius = 31'($urandom_range(0, 32'h0004_0000));
      p.b_radius = 31'($urandom_range(0, 32'h0004_0000));
      if (kind < 4) begin
        p.a_vel_x = $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
        p.a_vel_y = $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
        p.b_vel_x = $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
        p.b_vel_y = $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
      end
    end else if (kind < 8) begin
      // wide spacing with huge radii: overlap plus saturation of sums
      p.b_pos_x = $urandom;  p.b_pos_y = $urandom;
    end else begin
      // pure noise, mostly misses
      p.b_pos_x = $urandom;  p.b_pos_y = $urandom;
      p.a_radius = 31'($urandom_range(0, 32'h0010_0000));
    end
    return p;
  endfunction

  function automatic cpec_pkg::cpec_in_t pair_of(input logic signed [31:0] ax, ay, bx, by,
                                                 input logic signed [31:0] av, bv,
                                                 input logic [30:0] r, m1, m2);
    cpec_pkg::cpec_in_t p;
    p = '{a_pos_x: ax, a_pos_y: ay, a_vel_x: av, a_vel_y: -av, a_radius: r, a_mass: m1,
          b_pos_x: bx, b_pos_y: by, b_vel_x: bv, b_vel_y: ~bv, b_radius: r, b_mass: m2};
    return p;
  endfunction

  initial begin
    cpec_pkg::cpec_in_t directed[$];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: passes, coincident centres, extremes, equal and lopsided masses.
    directed.push_back('0);                                         // all zero, coincident
    directed.push_back(pair_of(32'sh0001_0000, 0, 32'sh0001_0000, 0,
                               32'sh0002_0000, 0, 31'h0001_0000, 31'd1, 31'd1)); // coincident
    directed.push_back(pair_of(0, 0, 32'sh000a_0000, 0, 32'sh0001_0000, -32'sh0001_0000,
                               31'h0001_0000, 31'h0001_0000, 31'h0001_0000)); // miss
    directed.push_back(pair_of(0, 0, 32'sh0002_0000, 0, 32'sh0001_0000, -32'sh0001_0000,
                               31'h0001_0000, 31'h0001_0000, 31'h0001_0000)); // just touching
    directed.push_back(pair_of(0, 0, 32'sh0001_8000, 32'sh0001_0000, 32'sh0003_0000,
                               -32'sh0002_0000, 31'h0001_0000, 31'h0001_0000,
                               31'h0001_0000));                     // head-on, equal masses
    directed.push_back(pair_of(0, 0, 1, 0, 32'sh0001_0000, 0, 31'd1, 31'd1,
                               31'h7fff_ffff));                     // tiny gap, lopsided
    directed.push_back(pair_of(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                               31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff)); // full span
    directed.push_back(pair_of(32'sh7fff_ffff, 0, 32'sh8000_0000, 0, 32'sh8000_0000,
                               32'sh7fff_ffff, 31'h7fff_ffff, 31'd1, 31'd1));  // reversed
    directed.push_back(pair_of(32'sh7fff_0000, 32'sh7fff_0000, 32'sh7fff_ffff,
                               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                               31'h7fff_ffff, 31'h7fff_ffff, 31'd1)); // push saturates
    directed.push_back(pair_of(0, 0, 0, 32'sh0000_8000, 32'sh8000_0000, 32'sh8000_0000,
                               31'h0001_0000, 31'h0000_0001, 31'h0000_0001)); // vertical
    directed.push_back(pair_of(-32'sh0000_4000, 32'sh0000_4000, 32'sh0000_4000,
                               -32'sh0000_4000, -32'sh0000_1000, 32'sh0000_2000,
                               31'h0000_8000, 31'h0003_0000, 31'h0000_1000)); // diagonal
    foreach (directed[i]) send_pair(directed[i]);

    // Hold off until the pipeline has drained completely.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 12 : (ph == 1) ? 80 : 0;
      repeat (330) send_pair(make_pair());
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Covered %0d circle pairs, %0d of them resolved as collisions,", pairs_seen,
             hits_seen);
    $display("under light, heavy and no sender idling, with one full drain mid-run.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
